FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the RTL. Define ASSERT_OFF
// to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/baeq_pkg.sv
// ---------------------------------------------------------------------------
// baeq_pkg
// Shared types, codes and constants of the button auto-repeat event queue.
// ---------------------------------------------------------------------------
package baeq_pkg;

	// Event queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Field widths
	localparam int OP_W    = 2;
	localparam int EV_W    = 4;
	localparam int TOUCH_W = 12;
	localparam int DISP_W  = 10;
	localparam int WIN_W   = 12;
	localparam int MS_W    = 16;
	localparam int TIME_W  = 32;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_POLL    = 2'd0;
	localparam logic [OP_W-1:0] OP_PRESS   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_TOUCH   = 2'd3;

	// Event codes
	localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
	localparam logic [EV_W-1:0] EV_PLAY     = 4'd1;
	localparam logic [EV_W-1:0] EV_PREV     = 4'd2;
	localparam logic [EV_W-1:0] EV_NEXT     = 4'd3;
	localparam logic [EV_W-1:0] EV_VOL_DOWN = 4'd7;
	localparam logic [EV_W-1:0] EV_BACK     = 4'd8;
	localparam logic [EV_W-1:0] EV_LAST     = 4'd9;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_DISP_W    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_DISP_H    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_WIN_W     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_WIN_H     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_REP_DELAY = 3'd4;
	localparam logic [CIDX_W-1:0] REG_REP_RATE  = 3'd5;

	// Configuration reset values
	localparam logic [DISP_W-1:0] RST_DISP_W    = 10'd320;
	localparam logic [DISP_W-1:0] RST_DISP_H    = 10'd240;
	localparam logic [WIN_W-1:0]  RST_WIN_W     = 12'd320;
	localparam logic [WIN_W-1:0]  RST_WIN_H     = 12'd240;
	localparam logic [MS_W-1:0]   RST_REP_DELAY = 16'd260;
	localparam logic [MS_W-1:0]   RST_REP_RATE  = 16'd90;

	// Touch zone percentages
	localparam int PCT_BACK = 18;
	localparam int PCT_PREV = 30;
	localparam int PCT_NEXT = 70;

	// floor(n/100) = (n * RECIP_100) >> RECIP_SHIFT, exact for n < 91180
	localparam int MUL_W       = 17;
	localparam int RECIP_SHIFT = 23;
	localparam logic [MUL_W-1:0] RECIP_100 = 17'd83887;

	// Touch arithmetic widths
	localparam int PROD_W = TOUCH_W + DISP_W;
	localparam int TH_W   = DISP_W;

	// Status of the touch zone unit
	typedef struct packed {
		logic            busy;
		logic [EV_W-1:0] zone;
	} tz_stat_t;

	// Ring pointer increment
	function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = QPTR_W'(p + 1'b1);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : n;
	endfunction

endpackage

FILE: rtl/baeq_touch_zone.sv
// ---------------------------------------------------------------------------
// baeq_touch_zone
// Classifies a touch into back / prev / next / play with one shared
// multiplier stepped through the sequencer steps. Divisions of the scaling
// are replaced by cross-multiplied compares: floor(a/b) < t  <=>  a < t*b.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module baeq_touch_zone import baeq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TOUCH_W-1:0] touch_x,
	input  logic [TOUCH_W-1:0] touch_y,
	input  logic [DISP_W-1:0]  display_width,
	input  logic [DISP_W-1:0]  display_height,
	input  logic [WIN_W-1:0]   window_width,
	input  logic [WIN_W-1:0]   window_height,
	output tz_stat_t           stat
);

	// Sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_AY  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_AX  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TB  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_TP  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_TN  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_BB  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_BP  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_BN  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_CMP = 4'd8;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [TOUCH_W-1:0] x_q, y_q;
	logic [PROD_W-1:0] ay_q, ax_q, bb_q, bp_q, bn_q;
	logic [TH_W-1:0]   tb_q, tp_q, tn_q;
	logic [EV_W-1:0]   zone_q;

	logic [WIN_W-1:0]   ww_eff, wh_eff;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod;

	// Zero window size counts as one
	assign ww_eff = (window_width  == '0) ? WIN_W'(1) : window_width;
	assign wh_eff = (window_height == '0) ? WIN_W'(1) : window_height;

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			STEP_AY: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(display_height);
			end
			STEP_AX: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(display_width);
			end
			STEP_TB: begin
				mul_a = MUL_W'(display_height) * MUL_W'(PCT_BACK);
				mul_b = RECIP_100;
			end
			STEP_TP: begin
				mul_a = MUL_W'(display_width) * MUL_W'(PCT_PREV);
				mul_b = RECIP_100;
			end
			STEP_TN: begin
				mul_a = MUL_W'(display_width) * MUL_W'(PCT_NEXT);
				mul_b = RECIP_100;
			end
			STEP_BB: begin
				mul_a = MUL_W'(tb_q);
				mul_b = MUL_W'(wh_eff);
			end
			STEP_BP: begin
				mul_a = MUL_W'(tp_q);
				mul_b = MUL_W'(ww_eff);
			end
			STEP_BN: begin
				// px > t  <=>  a >= (t+1)*b
				mul_a = MUL_W'(tn_q) + MUL_W'(1);
				mul_b = MUL_W'(ww_eff);
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Control: busy flag and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_AY;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_AY;
		end else if (busy_q) begin
			if (step_q == STEP_CMP) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= touch_x;
			y_q <= touch_y;
		end else if (busy_q) begin
			unique case (step_q)
				STEP_AY: ay_q <= prod[PROD_W-1:0];
				STEP_AX: ax_q <= prod[PROD_W-1:0];
				STEP_TB: tb_q <= prod[RECIP_SHIFT +: TH_W];
				STEP_TP: tp_q <= prod[RECIP_SHIFT +: TH_W];
				STEP_TN: tn_q <= prod[RECIP_SHIFT +: TH_W];
				STEP_BB: bb_q <= prod[PROD_W-1:0];
				STEP_BP: bp_q <= prod[PROD_W-1:0];
				STEP_BN: bn_q <= prod[PROD_W-1:0];
				STEP_CMP: begin
					priority if (ay_q < bb_q) begin
						zone_q <= EV_BACK;
					end else if (ax_q < bp_q) begin
						zone_q <= EV_PREV;
					end else if (ax_q >= bn_q) begin
						zone_q <= EV_NEXT;
					end else begin
						zone_q <= EV_PLAY;
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.zone = zone_q;

	`ASSERT_CLK(a_tz_done_at_cmp, clk, arst_n, $fell(busy_q) |-> ($past(step_q) == STEP_CMP), "touch unit finished before compare step")
	`ASSERT_CLK(a_tz_step_range, clk, arst_n, busy_q |-> (step_q <= STEP_CMP), "touch step counter out of range")

endmodule

FILE: rtl/button_autorepeat_event_queue_unit.sv
// ---------------------------------------------------------------------------
// button_autorepeat_event_queue_unit
// Key press / release / touch event handling with typematic auto-repeat and
// a 16-entry event ring; one event popped per poll.
// ---------------------------------------------------------------------------
// Each accepted request is one poll and returns exactly one result on the
// output channel (event_res 0 when the queue is empty). A poll, press or
// release passes from acceptance to result through the sequencer steps: it
// applies the event, checks auto-repeat, reads the queue memory (registered
// read) and loads the output register. A touch first waits in the zone unit,
// whose single shared multiplier forms the scaled coordinates, the zone
// thresholds and the cross products in turn. A new request is taken while a
// previous result still waits in the output register. The ring holds at most
// fifteen events; pushes to a full ring are dropped. Configuration registers
// are written through cfg_wr_en / cfg_index / cfg_data; the user writes them
// only while the block is idle, and the block does not check it.
`include "assert_macros.svh"

module button_autorepeat_event_queue_unit import baeq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    operation,
	input  logic [EV_W-1:0]    button,
	input  logic [TOUCH_W-1:0] touch_x,
	input  logic [TOUCH_W-1:0] touch_y,
	input  logic [TIME_W-1:0]  now_ms,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [EV_W-1:0]    event_res,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDATA_W-1:0] cfg_data
);

	// Sequencer states
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
	localparam logic [ST_W-1:0] ST_EVENT  = 3'd1;
	localparam logic [ST_W-1:0] ST_REPEAT = 3'd2;
	localparam logic [ST_W-1:0] ST_READ   = 3'd3;
	localparam logic [ST_W-1:0] ST_DONE   = 3'd4;

	logic [ST_W-1:0]   state_q;
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [EV_W-1:0]   held_q;
	logic [TIME_W-1:0] press_time_q, repeat_time_q;
	logic              out_valid_q;
	logic              hit_q;
	logic [EV_W-1:0]   res_q;
	logic [EV_W-1:0]   rd_q;

	// Captured request
	logic [OP_W-1:0]   op_q;
	logic [EV_W-1:0]   btn_q;
	logic [TIME_W-1:0] now_q;

	// Configuration registers
	logic [DISP_W-1:0] disp_w_q, disp_h_q;
	logic [WIN_W-1:0]  win_w_q, win_h_q;
	logic [MS_W-1:0]   rep_delay_q, rep_rate_q;

	logic [EV_W-1:0] event_store [QUEUE_DEPTH];

	logic            mem_we, mem_re;
	logic [EV_W-1:0] mem_wdata;
	logic            ring_full, press_ok, held_rep, rep_due;
	logic            in_acc, out_load, tz_start;
	tz_stat_t        tz_stat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign tz_start  = in_acc && (operation == OP_TOUCH);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign event_res = res_q;

	// Touch zone classifier
	baeq_touch_zone u_touch (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (tz_start),
		.touch_x        (touch_x),
		.touch_y        (touch_y),
		.display_width  (disp_w_q),
		.display_height (disp_h_q),
		.window_width   (win_w_q),
		.window_height  (win_h_q),
		.stat           (tz_stat)
	);

	// Queue and repeat conditions
	assign ring_full = (ring_next(wp_q) == rp_q);
	assign press_ok  = (btn_q != EV_NONE) && (btn_q <= EV_LAST);
	assign held_rep  = (held_q >= EV_PREV) && (held_q <= EV_VOL_DOWN);
	assign rep_due   = held_rep
		&& (TIME_W'(now_q - press_time_q)  >= TIME_W'(rep_delay_q))
		&& (TIME_W'(now_q - repeat_time_q) >= TIME_W'(rep_rate_q));

	// Queue memory access per step
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = btn_q;
		unique case (state_q)
			ST_EVENT: begin
				if (!tz_stat.busy) begin
					if (op_q == OP_PRESS && press_ok) begin
						mem_we    = !ring_full;
						mem_wdata = btn_q;
					end else if (op_q == OP_TOUCH) begin
						mem_we    = !ring_full;
						mem_wdata = tz_stat.zone;
					end
				end
			end
			ST_REPEAT: begin
				if (rep_due) begin
					mem_we    = !ring_full;
					mem_wdata = held_q;
				end
			end
			ST_READ: mem_re = (rp_q != wp_q);
			default: ;
		endcase
	end

	// Event ring memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			event_store[wp_q] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= event_store[rp_q];
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= operation;
			btn_q <= button;
			now_q <= now_ms;
		end
		if (out_load) begin
			res_q <= hit_q ? rd_q : EV_NONE;
		end
	end

	// Control state, pointers, held key and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			rp_q          <= '0;
			held_q        <= EV_NONE;
			press_time_q  <= '0;
			repeat_time_q <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			disp_w_q      <= RST_DISP_W;
			disp_h_q      <= RST_DISP_H;
			win_w_q       <= RST_WIN_W;
			win_h_q       <= RST_WIN_H;
			rep_delay_q   <= RST_REP_DELAY;
			rep_rate_q    <= RST_REP_RATE;
		end else begin
			// configuration writes; unknown indexes ignored
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_DISP_W:    disp_w_q    <= cfg_data[DISP_W-1:0];
					REG_DISP_H:    disp_h_q    <= cfg_data[DISP_W-1:0];
					REG_WIN_W:     win_w_q     <= cfg_data[WIN_W-1:0];
					REG_WIN_H:     win_h_q     <= cfg_data[WIN_W-1:0];
					REG_REP_DELAY: rep_delay_q <= cfg_data[MS_W-1:0];
					REG_REP_RATE:  rep_rate_q  <= cfg_data[MS_W-1:0];
					default: ;
				endcase
			end

			if (mem_we) begin
				wp_q <= ring_next(wp_q);
			end
			if (mem_re) begin
				rp_q <= ring_next(rp_q);
			end

			// result register: a new load wins over the handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVENT;
					end
				end
				ST_EVENT: begin
					// touch waits for the zone unit
					if (!tz_stat.busy) begin
						if (op_q == OP_PRESS && press_ok) begin
							held_q        <= btn_q;
							press_time_q  <= now_q;
							repeat_time_q <= now_q;
						end else if (op_q == OP_RELEASE) begin
							held_q <= EV_NONE;
						end
						state_q <= ST_REPEAT;
					end
				end
				ST_REPEAT: begin
					if (rep_due) begin
						repeat_time_q <= now_q;
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					hit_q   <= (rp_q != wp_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_tz_start_idle, clk, arst_n, tz_start |-> !tz_stat.busy, "touch started while zone unit busy")
	`ASSERT_CLK(a_rp_in_read, clk, arst_n, !$stable(rp_q) |-> ($past(state_q) == ST_READ), "read pointer moved outside read step")
	`ASSERT_CLK(a_out_from_done, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside done step")
	`ASSERT_CLK(a_push_steps, clk, arst_n, mem_we |-> (state_q == ST_EVENT || state_q == ST_REPEAT), "queue write outside push steps")

endmodule
